FILE: rtl/lavm_pkg.sv
// ----------------------------------------------------------------------------
// lavm_pkg
// Shared types and constants for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lavm_pkg;

  localparam int ENTRY_W    = 32;
  localparam int LEN_W      = 32;
  localparam int SQRT_STEPS = 32;

  localparam logic [1:0] ROW_X    = 2'd0;
  localparam logic [1:0] ROW_Y    = 2'd1;
  localparam logic [1:0] ROW_Z    = 2'd2;
  localparam logic [1:0] ROW_LAST = 2'd3;

  typedef struct packed {
    logic signed [ENTRY_W-1:0] e0;
    logic signed [ENTRY_W-1:0] e1;
    logic signed [ENTRY_W-1:0] e2;
    logic signed [ENTRY_W-1:0] e3;
  } axis_row_t;

  typedef struct packed {
    logic            ok;
    axis_row_t [2:0] rows;
  } rowset_t;

endpackage

FILE: rtl/lavm_norm.sv
// ----------------------------------------------------------------------------
// lavm_norm
// Pipelined 3-vector normalizer: prescale, sum of squares, bitwise square
// root, restoring division. One step per stage, sideband carried alongside.
// ----------------------------------------------------------------------------
module lavm_norm #(
  parameter int W    = 32,
  parameter int NSH  = 0,
  parameter int FRAC = 16,
  parameter int SB_W = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic signed [W-1:0]    in_v [3],
  input  logic [SB_W-1:0]        in_sb,
  output logic                   out_vld,
  output logic                   out_ok,
  output logic signed [FRAC+1:0] out_n [3],
  output logic [SB_W-1:0]        out_sb
);

  localparam int QW = FRAC + 1;
  localparam int NW = FRAC + 2;
  localparam int LW = lavm_pkg::LEN_W;
  localparam int SQ = lavm_pkg::SQRT_STEPS;
  localparam logic [W:0] LIM = (W+1)'(64'h8000_0000);

  // prescale stages
  logic [W-1:0]    sh_m_r   [NSH+1][3];
  logic [W-1:0]    sh_mx_r  [NSH+1];
  logic [2:0]      sh_neg_r [NSH+1];
  logic [SB_W-1:0] sh_sb_r  [NSH+1];
  logic            sh_vld_r [NSH+1];

  logic [W-1:0] mag_c [3];
  logic [W-1:0] mx_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = in_v[i][W-1] ? W'(-in_v[i]) : W'(in_v[i]);
    end
    mx_c = mag_c[0];
    if (mag_c[1] > mx_c) mx_c = mag_c[1];
    if (mag_c[2] > mx_c) mx_c = mag_c[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sh_m_r[0]   <= mag_c;
      sh_mx_r[0]  <= mx_c;
      sh_neg_r[0] <= {in_v[2][W-1], in_v[1][W-1], in_v[0][W-1]};
      sh_sb_r[0]  <= in_sb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_vld_r[0] <= 1'b0;
    end else if (en) begin
      sh_vld_r[0] <= in_vld;
    end
  end

  for (genvar k = 0; k < NSH; k++) begin : g_sh
    always_ff @(posedge clk) begin
      if (en) begin
        // shift all three while the largest is above 2^31
        if ({1'b0, sh_mx_r[k]} > LIM) begin
          for (int i = 0; i < 3; i++) begin
            sh_m_r[k+1][i] <= sh_m_r[k][i] >> 1;
          end
          sh_mx_r[k+1] <= sh_mx_r[k] >> 1;
        end else begin
          sh_m_r[k+1]  <= sh_m_r[k];
          sh_mx_r[k+1] <= sh_mx_r[k];
        end
        sh_neg_r[k+1] <= sh_neg_r[k];
        sh_sb_r[k+1]  <= sh_sb_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sh_vld_r[k+1] <= 1'b0;
      end else if (en) begin
        sh_vld_r[k+1] <= sh_vld_r[k];
      end
    end
  end

  // squares
  logic [LW-1:0]   m32_c   [3];
  logic [LW-1:0]   sq_m_r  [3];
  logic [2*LW-1:0] sq_p_r  [3];
  logic [2:0]      sq_neg_r;
  logic [SB_W-1:0] sq_sb_r;
  logic            sq_vld_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m32_c[i] = LW'(sh_m_r[NSH][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_m_r[i] <= m32_c[i];
        sq_p_r[i] <= (2*LW)'(m32_c[i]) * (2*LW)'(m32_c[i]);
      end
      sq_neg_r <= sh_neg_r[NSH];
      sq_sb_r  <= sh_sb_r[NSH];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
    end else if (en) begin
      sq_vld_r <= sh_vld_r[NSH];
    end
  end

  // square root stages, index 0 holds the sum
  logic [2*LW-1:0] rt_n_r   [SQ+1];
  logic [2*LW-1:0] rt_res_r [SQ+1];
  logic [LW-1:0]   rt_m_r   [SQ+1][3];
  logic [2:0]      rt_neg_r [SQ+1];
  logic            rt_ok_r  [SQ+1];
  logic [SB_W-1:0] rt_sb_r  [SQ+1];
  logic            rt_vld_r [SQ+1];
  logic [2*LW-1:0] sum_c;

  assign sum_c = sq_p_r[0] + sq_p_r[1] + sq_p_r[2];

  always_ff @(posedge clk) begin
    if (en) begin
      rt_n_r[0]   <= sum_c;
      rt_res_r[0] <= '0;
      rt_m_r[0]   <= sq_m_r;
      rt_neg_r[0] <= sq_neg_r;
      rt_ok_r[0]  <= (sum_c != '0);
      rt_sb_r[0]  <= sq_sb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_vld_r[0] <= 1'b0;
    end else if (en) begin
      rt_vld_r[0] <= sq_vld_r;
    end
  end

  for (genvar j = 0; j < SQ; j++) begin : g_rt
    localparam logic [2*LW-1:0] BIT = (2*LW)'(1) << (2*LW - 2 - 2*j);
    logic [2*LW-1:0] trial;
    assign trial = rt_res_r[j] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rt_n_r[j] >= trial) begin
          rt_n_r[j+1]   <= rt_n_r[j] - trial;
          rt_res_r[j+1] <= (rt_res_r[j] >> 1) + BIT;
        end else begin
          rt_n_r[j+1]   <= rt_n_r[j];
          rt_res_r[j+1] <= rt_res_r[j] >> 1;
        end
        rt_m_r[j+1]   <= rt_m_r[j];
        rt_neg_r[j+1] <= rt_neg_r[j];
        rt_ok_r[j+1]  <= rt_ok_r[j];
        rt_sb_r[j+1]  <= rt_sb_r[j];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_vld_r[j+1] <= 1'b0;
      end else if (en) begin
        rt_vld_r[j+1] <= rt_vld_r[j];
      end
    end
  end

  // division stages, index 0 holds the integer quotient bit
  logic [LW:0]     dv_rem_r [FRAC+1][3];
  logic [QW-1:0]   dv_q_r   [FRAC+1][3];
  logic [LW-1:0]   dv_len_r [FRAC+1];
  logic [2:0]      dv_neg_r [FRAC+1];
  logic            dv_ok_r  [FRAC+1];
  logic [SB_W-1:0] dv_sb_r  [FRAC+1];
  logic            dv_vld_r [FRAC+1];

  logic [LW-1:0] len_c;
  logic          ge0_c  [3];
  logic [LW:0]   rem0_c [3];

  always_comb begin
    len_c = rt_res_r[SQ][LW-1:0];
    for (int i = 0; i < 3; i++) begin
      ge0_c[i]  = rt_m_r[SQ][i] >= len_c;
      rem0_c[i] = ge0_c[i] ? ({1'b0, rt_m_r[SQ][i]} - {1'b0, len_c})
                           : {1'b0, rt_m_r[SQ][i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= rem0_c[i];
        dv_q_r[0][i]   <= QW'(ge0_c[i]);
      end
      dv_len_r[0] <= len_c;
      dv_neg_r[0] <= rt_neg_r[SQ];
      dv_ok_r[0]  <= rt_ok_r[SQ];
      dv_sb_r[0]  <= rt_sb_r[SQ];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (en) begin
      dv_vld_r[0] <= rt_vld_r[SQ];
    end
  end

  for (genvar d = 0; d < FRAC; d++) begin : g_dv
    logic [LW:0] r2   [3];
    logic [LW:0] nrem [3];
    logic        bq   [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r2[i]   = {dv_rem_r[d][i][LW-1:0], 1'b0};
        bq[i]   = r2[i] >= {1'b0, dv_len_r[d]};
        nrem[i] = bq[i] ? (r2[i] - {1'b0, dv_len_r[d]}) : r2[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[d+1][i] <= nrem[i];
          dv_q_r[d+1][i]   <= {dv_q_r[d][i][QW-2:0], bq[i]};
        end
        dv_len_r[d+1] <= dv_len_r[d];
        dv_neg_r[d+1] <= dv_neg_r[d];
        dv_ok_r[d+1]  <= dv_ok_r[d];
        dv_sb_r[d+1]  <= dv_sb_r[d];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[d+1] <= 1'b0;
      end else if (en) begin
        dv_vld_r[d+1] <= dv_vld_r[d];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_n[i] = dv_neg_r[FRAC][i] ? -NW'(dv_q_r[FRAC][i]) : NW'(dv_q_r[FRAC][i]);
    end
  end

  assign out_vld = dv_vld_r[FRAC];
  assign out_ok  = dv_ok_r[FRAC];
  assign out_sb  = dv_sb_r[FRAC];

endmodule

FILE: rtl/lavm_cross.sv
// ----------------------------------------------------------------------------
// lavm_cross
// Two-stage exact cross product of the up hint with the z axis.
// ----------------------------------------------------------------------------
module lavm_cross #(
  parameter int FRAC = 16,
  parameter int SB_W = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic signed [31:0]      in_up [3],
  input  logic signed [FRAC+1:0]  in_z  [3],
  input  logic [SB_W-1:0]         in_sb,
  output logic                    out_vld,
  output logic signed [FRAC+33:0] out_c [3],
  output logic [SB_W-1:0]         out_sb
);

  localparam int PW = FRAC + 34;

  logic signed [PW-1:0] p_r [6];
  logic [SB_W-1:0]      p_sb_r;
  logic                 p_vld_r;
  logic signed [PW-1:0] c_r [3];
  logic [SB_W-1:0]      c_sb_r;
  logic                 c_vld_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= PW'(in_up[1]) * PW'(in_z[2]);
      p_r[1] <= PW'(in_up[2]) * PW'(in_z[1]);
      p_r[2] <= PW'(in_up[2]) * PW'(in_z[0]);
      p_r[3] <= PW'(in_up[0]) * PW'(in_z[2]);
      p_r[4] <= PW'(in_up[0]) * PW'(in_z[1]);
      p_r[5] <= PW'(in_up[1]) * PW'(in_z[0]);
      p_sb_r <= in_sb;
      c_r[0] <= p_r[0] - p_r[1];
      c_r[1] <= p_r[2] - p_r[3];
      c_r[2] <= p_r[4] - p_r[5];
      c_sb_r <= p_sb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r <= in_vld;
      c_vld_r <= p_vld_r;
    end
  end

  assign out_vld = c_vld_r;
  assign out_c   = c_r;
  assign out_sb  = c_sb_r;

endmodule

FILE: rtl/lavm_rows.sv
// ----------------------------------------------------------------------------
// lavm_rows
// Forms the y axis and the three translation terms, then packs the rows.
// ----------------------------------------------------------------------------
module lavm_rows #(
  parameter int FRAC = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic                   in_ok,
  input  logic signed [FRAC+1:0] in_x [3],
  input  logic signed [FRAC+1:0] in_z [3],
  input  logic signed [31:0]     in_o [3],
  output logic                   out_vld,
  output lavm_pkg::rowset_t      out_rows
);

  localparam int NW  = FRAC + 2;
  localparam int YPW = 2 * NW;
  localparam int DW  = YPW + 1;
  localparam int YW  = NW + 1;
  localparam int TW  = NW + 36;
  localparam logic signed [TW-1:0] SMAX = TW'(64'sd2147483647);
  localparam logic signed [TW-1:0] SMIN = -SMAX - TW'(1);

  function automatic logic signed [YW-1:0] drop_y(input logic signed [DW-1:0] d);
    logic [DW-1:0] mg;
    logic [DW-1:0] q;
    mg = d[DW-1] ? DW'(-d) : DW'(d);
    q  = mg >> FRAC;
    return d[DW-1] ? -YW'(q) : YW'(q);
  endfunction

  // minus the dot product, truncated toward zero, then saturated
  function automatic logic signed [31:0] trans_sat(input logic signed [TW-1:0] d);
    logic [TW-1:0]        mg;
    logic [TW-1:0]        q;
    logic signed [TW-1:0] t;
    mg = d[TW-1] ? TW'(-d) : TW'(d);
    q  = mg >> FRAC;
    t  = d[TW-1] ? signed'(q) : -signed'(q);
    if (t > SMAX) begin
      t = SMAX;
    end else if (t < SMIN) begin
      t = SMIN;
    end
    return t[31:0];
  endfunction

  // stage 1: products
  logic signed [YPW-1:0] s1_yp_r [6];
  logic signed [TW-1:0]  s1_xp_r [3];
  logic signed [TW-1:0]  s1_zp_r [3];
  logic signed [NW-1:0]  s1_x_r  [3];
  logic signed [NW-1:0]  s1_z_r  [3];
  logic signed [31:0]    s1_o_r  [3];
  logic                  s1_ok_r;

  // stage 2: y axis, x and z dot products
  logic signed [YW-1:0]  s2_y_r [3];
  logic signed [TW-1:0]  s2_dx_r;
  logic signed [TW-1:0]  s2_dz_r;
  logic signed [NW-1:0]  s2_x_r [3];
  logic signed [NW-1:0]  s2_z_r [3];
  logic signed [31:0]    s2_o_r [3];
  logic                  s2_ok_r;

  // stage 3: y products, x and z translations
  logic signed [TW-1:0]  s3_yp_r [3];
  logic signed [31:0]    s3_tx_r;
  logic signed [31:0]    s3_tz_r;
  logic signed [YW-1:0]  s3_y_r [3];
  logic signed [NW-1:0]  s3_x_r [3];
  logic signed [NW-1:0]  s3_z_r [3];
  logic                  s3_ok_r;

  // stage 4: y dot product
  logic signed [TW-1:0]  s4_dy_r;
  logic signed [31:0]    s4_tx_r;
  logic signed [31:0]    s4_tz_r;
  logic signed [YW-1:0]  s4_y_r [3];
  logic signed [NW-1:0]  s4_x_r [3];
  logic signed [NW-1:0]  s4_z_r [3];
  logic                  s4_ok_r;

  lavm_pkg::rowset_t     s5_rows_r;
  logic [4:0]            vld_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_yp_r[0] <= YPW'(in_z[1]) * YPW'(in_x[2]);
      s1_yp_r[1] <= YPW'(in_z[2]) * YPW'(in_x[1]);
      s1_yp_r[2] <= YPW'(in_z[2]) * YPW'(in_x[0]);
      s1_yp_r[3] <= YPW'(in_z[0]) * YPW'(in_x[2]);
      s1_yp_r[4] <= YPW'(in_z[0]) * YPW'(in_x[1]);
      s1_yp_r[5] <= YPW'(in_z[1]) * YPW'(in_x[0]);
      for (int i = 0; i < 3; i++) begin
        s1_xp_r[i] <= TW'(in_x[i]) * TW'(in_o[i]);
        s1_zp_r[i] <= TW'(in_z[i]) * TW'(in_o[i]);
      end
      s1_x_r  <= in_x;
      s1_z_r  <= in_z;
      s1_o_r  <= in_o;
      s1_ok_r <= in_ok;

      s2_y_r[0] <= drop_y(DW'(s1_yp_r[0]) - DW'(s1_yp_r[1]));
      s2_y_r[1] <= drop_y(DW'(s1_yp_r[2]) - DW'(s1_yp_r[3]));
      s2_y_r[2] <= drop_y(DW'(s1_yp_r[4]) - DW'(s1_yp_r[5]));
      s2_dx_r   <= s1_xp_r[0] + s1_xp_r[1] + s1_xp_r[2];
      s2_dz_r   <= s1_zp_r[0] + s1_zp_r[1] + s1_zp_r[2];
      s2_x_r    <= s1_x_r;
      s2_z_r    <= s1_z_r;
      s2_o_r    <= s1_o_r;
      s2_ok_r   <= s1_ok_r;

      for (int i = 0; i < 3; i++) begin
        s3_yp_r[i] <= TW'(s2_y_r[i]) * TW'(s2_o_r[i]);
      end
      s3_tx_r <= trans_sat(s2_dx_r);
      s3_tz_r <= trans_sat(s2_dz_r);
      s3_y_r  <= s2_y_r;
      s3_x_r  <= s2_x_r;
      s3_z_r  <= s2_z_r;
      s3_ok_r <= s2_ok_r;

      s4_dy_r <= s3_yp_r[0] + s3_yp_r[1] + s3_yp_r[2];
      s4_tx_r <= s3_tx_r;
      s4_tz_r <= s3_tz_r;
      s4_y_r  <= s3_y_r;
      s4_x_r  <= s3_x_r;
      s4_z_r  <= s3_z_r;
      s4_ok_r <= s3_ok_r;

      s5_rows_r.ok         <= s4_ok_r;
      s5_rows_r.rows[0].e0 <= 32'(s4_x_r[0]);
      s5_rows_r.rows[0].e1 <= 32'(s4_x_r[1]);
      s5_rows_r.rows[0].e2 <= 32'(s4_x_r[2]);
      s5_rows_r.rows[0].e3 <= s4_tx_r;
      s5_rows_r.rows[1].e0 <= 32'(s4_y_r[0]);
      s5_rows_r.rows[1].e1 <= 32'(s4_y_r[1]);
      s5_rows_r.rows[1].e2 <= 32'(s4_y_r[2]);
      s5_rows_r.rows[1].e3 <= trans_sat(s4_dy_r);
      s5_rows_r.rows[2].e0 <= 32'(s4_z_r[0]);
      s5_rows_r.rows[2].e1 <= 32'(s4_z_r[1]);
      s5_rows_r.rows[2].e2 <= 32'(s4_z_r[2]);
      s5_rows_r.rows[2].e3 <= s4_tz_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  assign out_vld  = vld_r[4];
  assign out_rows = s5_rows_r;

endmodule

FILE: rtl/lavm_ser.sv
// ----------------------------------------------------------------------------
// lavm_ser
// Output register: holds one matrix and hands it out row by row.
// ----------------------------------------------------------------------------
module lavm_ser #(
  parameter int FRAC = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  lavm_pkg::rowset_t  in_rows,
  output logic               en,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_row_index,
  output logic signed [31:0] out_entry_0,
  output logic signed [31:0] out_entry_1,
  output logic signed [31:0] out_entry_2,
  output logic signed [31:0] out_entry_3,
  output logic               out_last_row,
  output logic               out_degenerate
);

  localparam logic signed [31:0] ONE = 32'(1) << FRAC;

  logic                busy_r;
  logic [1:0]          cnt_r;
  lavm_pkg::rowset_t   data_r;
  lavm_pkg::axis_row_t row_c;

  // advance the pipeline when empty or when the last row leaves
  assign en = !busy_r || (!out_stall && cnt_r == lavm_pkg::ROW_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= lavm_pkg::ROW_X;
    end else if (en) begin
      busy_r <= in_vld;
      cnt_r  <= lavm_pkg::ROW_X;
    end else if (!out_stall) begin
      cnt_r <= cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_vld) begin
      data_r <= in_rows;
    end
  end

  always_comb begin
    unique case (cnt_r)
      lavm_pkg::ROW_X: row_c = data_r.rows[0];
      lavm_pkg::ROW_Y: row_c = data_r.rows[1];
      lavm_pkg::ROW_Z: row_c = data_r.rows[2];
      lavm_pkg::ROW_LAST: begin
        row_c    = '0;
        row_c.e3 = ONE;
      end
    endcase
    if (!data_r.ok) begin
      row_c = '0;
    end
  end

  assign out_valid      = busy_r;
  assign out_row_index  = cnt_r;
  assign out_entry_0    = row_c.e0;
  assign out_entry_1    = row_c.e1;
  assign out_entry_2    = row_c.e2;
  assign out_entry_3    = row_c.e3;
  assign out_last_row   = (cnt_r == lavm_pkg::ROW_LAST);
  assign out_degenerate = !data_r.ok;

endmodule

FILE: rtl/look_at_view_matrix_top.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix_top
// Right-handed look-at view matrix in signed fixed point, row by row.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one request: camera origin, viewing direction
//   and up hint, each as three signed Q.FRAC_BITS words. The result channel
//   returns four rows per request, row_index 0 to 3, last_row on row 3.
//   A zero direction or an up hint parallel to it gives four zero rows with
//   degenerate set.
//   The two normalizers each run a 32-step square root and a FRAC_BITS+1
//   step division, one step a stage. The single result channel carries
//   four rows per request and so limits throughput; the pipeline itself
//   takes one request per cycle while not frozen. When the receiver stalls,
//   the current row holds. The whole pipeline freezes while a held matrix
//   is not yet fully taken, and in_stall rises with it. Reset clears all
//   valid bits; nothing is in flight.
// ----------------------------------------------------------------------------
module look_at_view_matrix_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic signed [31:0] in_dir_z,
  input  logic signed [31:0] in_up_x,
  input  logic signed [31:0] in_up_y,
  input  logic signed [31:0] in_up_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_row_index,
  output logic signed [31:0] out_entry_0,
  output logic signed [31:0] out_entry_1,
  output logic signed [31:0] out_entry_2,
  output logic signed [31:0] out_entry_3,
  output logic               out_last_row,
  output logic               out_degenerate
);

  localparam int NW   = FRAC_BITS + 2;
  localparam int CW   = FRAC_BITS + 34;
  localparam int SB1W = 192;
  localparam int SB2W = 97 + 3 * NW;
  localparam int ZO   = 1;
  localparam int OO   = 1 + 3 * NW;

  logic en;

  // direction normalizer
  logic signed [31:0] dir_v [3];
  logic [SB1W-1:0]    sb1_in;
  logic               dn_vld;
  logic               dn_ok;
  logic signed [NW-1:0] dn_n [3];
  logic [SB1W-1:0]    dn_sb;

  assign dir_v[0] = in_dir_x;
  assign dir_v[1] = in_dir_y;
  assign dir_v[2] = in_dir_z;
  assign sb1_in   = {in_origin_x, in_origin_y, in_origin_z, in_up_x, in_up_y, in_up_z};

  lavm_norm #(.W(32), .NSH(0), .FRAC(FRAC_BITS), .SB_W(SB1W)) u_dnorm (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid),
    .in_v   (dir_v),
    .in_sb  (sb1_in),
    .out_vld(dn_vld),
    .out_ok (dn_ok),
    .out_n  (dn_n),
    .out_sb (dn_sb)
  );

  // z is the negated unit direction
  logic signed [31:0]   up_v [3];
  logic signed [NW-1:0] z_v  [3];
  logic [SB2W-1:0]      sb2_in;

  assign up_v[0] = dn_sb[95:64];
  assign up_v[1] = dn_sb[63:32];
  assign up_v[2] = dn_sb[31:0];
  assign z_v[0]  = -dn_n[0];
  assign z_v[1]  = -dn_n[1];
  assign z_v[2]  = -dn_n[2];
  assign sb2_in  = {dn_sb[191:96], z_v[0], z_v[1], z_v[2], dn_ok};

  logic                 cr_vld;
  logic signed [CW-1:0] cr_c [3];
  logic [SB2W-1:0]      cr_sb;

  lavm_cross #(.FRAC(FRAC_BITS), .SB_W(SB2W)) u_cross (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (dn_vld),
    .in_up  (up_v),
    .in_z   (z_v),
    .in_sb  (sb2_in),
    .out_vld(cr_vld),
    .out_c  (cr_c),
    .out_sb (cr_sb)
  );

  // x axis normalizer
  logic                 xn_vld;
  logic                 xn_ok;
  logic signed [NW-1:0] xn_n [3];
  logic [SB2W-1:0]      xn_sb;

  lavm_norm #(.W(CW), .NSH(FRAC_BITS + 1), .FRAC(FRAC_BITS), .SB_W(SB2W)) u_xnorm (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (cr_vld),
    .in_v   (cr_c),
    .in_sb  (cr_sb),
    .out_vld(xn_vld),
    .out_ok (xn_ok),
    .out_n  (xn_n),
    .out_sb (xn_sb)
  );

  logic signed [NW-1:0] zr_v [3];
  logic signed [31:0]   o_v  [3];
  logic                 all_ok;

  assign zr_v[0] = xn_sb[ZO + 3*NW - 1 : ZO + 2*NW];
  assign zr_v[1] = xn_sb[ZO + 2*NW - 1 : ZO + NW];
  assign zr_v[2] = xn_sb[ZO + NW - 1 : ZO];
  assign o_v[0]  = xn_sb[OO + 95 : OO + 64];
  assign o_v[1]  = xn_sb[OO + 63 : OO + 32];
  assign o_v[2]  = xn_sb[OO + 31 : OO];
  assign all_ok  = xn_sb[0] && xn_ok;

  logic              rw_vld;
  lavm_pkg::rowset_t rw_rows;

  lavm_rows #(.FRAC(FRAC_BITS)) u_rows (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (xn_vld),
    .in_ok   (all_ok),
    .in_x    (xn_n),
    .in_z    (zr_v),
    .in_o    (o_v),
    .out_vld (rw_vld),
    .out_rows(rw_rows)
  );

  lavm_ser #(.FRAC(FRAC_BITS)) u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_vld        (rw_vld),
    .in_rows       (rw_rows),
    .en            (en),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row_index (out_row_index),
    .out_entry_0   (out_entry_0),
    .out_entry_1   (out_entry_1),
    .out_entry_2   (out_entry_2),
    .out_entry_3   (out_entry_3),
    .out_last_row  (out_last_row),
    .out_degenerate(out_degenerate)
  );

  assign in_stall = !en;

endmodule

FILE: rtl/lavm_chk.sv
// ----------------------------------------------------------------------------
// lavm_chk
// Port-level checks on the row sequence of the view matrix block.
// ----------------------------------------------------------------------------
module lavm_chk #(
  parameter int FRAC_BITS = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_row_index,
  input logic signed [31:0] out_entry_0,
  input logic signed [31:0] out_entry_1,
  input logic signed [31:0] out_entry_2,
  input logic signed [31:0] out_entry_3,
  input logic               out_last_row,
  input logic               out_degenerate
);

  localparam logic signed [31:0] ONE = 32'(1) << FRAC_BITS;

  // rows of one matrix follow each other with the same degenerate flag
  a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_row |=>
      out_valid && out_row_index == $past(out_row_index) + 2'd1 &&
      $stable(out_degenerate))
    else $error("row sequence broken");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_last_row == (out_row_index == 2'd3))
    else $error("last_row mismatch");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_entry_0 == 32'sd0 && out_entry_1 == 32'sd0 &&
      out_entry_2 == 32'sd0 && out_entry_3 == 32'sd0)
    else $error("degenerate row not zero");

  a_const_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_row && !out_degenerate |->
      out_entry_0 == 32'sd0 && out_entry_1 == 32'sd0 &&
      out_entry_2 == 32'sd0 && out_entry_3 == ONE)
    else $error("last row not 0,0,0,1");

endmodule

bind look_at_view_matrix_top lavm_chk #(.FRAC_BITS(FRAC_BITS)) u_lavm_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_row_index (out_row_index),
  .out_entry_0   (out_entry_0),
  .out_entry_1   (out_entry_1),
  .out_entry_2   (out_entry_2),
  .out_entry_3   (out_entry_3),
  .out_last_row  (out_last_row),
  .out_degenerate(out_degenerate)
);

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for look_at_view_matrix_top. Sends camera requests (origin,
// direction, up hint), builds the expected four matrix rows of each one with
// its own fixed-point model and compares every row the block returns. The
// sender idles and receiver stalls in random bursts; last part has neither.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC      = 16;
  localparam int LATENCY   = 3 * FRAC + 81;
  localparam int MAX_ERRS  = 10;

  typedef longint vec3_t [3];

  typedef struct {
    logic [1:0]         row_idx;
    logic signed [31:0] e0;
    logic signed [31:0] e1;
    logic signed [31:0] e2;
    logic signed [31:0] e3;
    logic               last;
    logic               degen;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [31:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic signed [31:0] in_up_x = '0, in_up_y = '0, in_up_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_row_index;
  logic signed [31:0] out_entry_0, out_entry_1, out_entry_2, out_entry_3;
  logic out_last_row, out_degenerate;

  row_t rows_pending[$];
  int   mismatches = 0;
  bit   quiet = 1'b0;

  look_at_view_matrix_top #(.FRAC_BITS(FRAC)) u_top (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- model
  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint with_sign(bit neg, longint unsigned m);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint trunc_frac(longint v);
    return with_sign(v < 0, mag(v) >> FRAC);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic bit unit_vec(input vec3_t v, output vec3_t n);
    longint unsigned m[3], mx, sum, len;
    int s;
    mx = 0;
    sum = 0;
    s = 0;
    n = '{0, 0, 0};
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    while ((mx >> s) > 64'h8000_0000) s++;
    for (int i = 0; i < 3; i++) begin
      m[i] >>= s;
      sum += m[i] * m[i];
    end
    if (sum == 0) return 1'b0;
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) n[i] = with_sign(v[i] < 0, (m[i] << FRAC) / len);
    return 1'b1;
  endfunction

  function automatic logic signed [31:0] translation(vec3_t a, vec3_t o);
    longint t;
    t = trunc_frac(-(a[0] * o[0] + a[1] * o[1] + a[2] * o[2]));
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return t[31:0];
  endfunction

  task automatic predict_view_rows(vec3_t o, vec3_t d, vec3_t u);
    vec3_t nd, z, c, x, y;
    longint m[4][4];
    bit ok;
    row_t r;
    m = '{default: '{default: 0}};
    z = '{0, 0, 0};
    x = '{0, 0, 0};
    ok = unit_vec(d, nd);
    if (ok) begin
      for (int i = 0; i < 3; i++) z[i] = -nd[i];
      c[0] = u[1] * z[2] - u[2] * z[1];
      c[1] = u[2] * z[0] - u[0] * z[2];
      c[2] = u[0] * z[1] - u[1] * z[0];
      ok = unit_vec(c, x);
    end
    if (ok) begin
      y[0] = trunc_frac(z[1] * x[2] - z[2] * x[1]);
      y[1] = trunc_frac(z[2] * x[0] - z[0] * x[2]);
      y[2] = trunc_frac(z[0] * x[1] - z[1] * x[0]);
      for (int i = 0; i < 3; i++) begin
        m[0][i] = x[i];
        m[1][i] = y[i];
        m[2][i] = z[i];
      end
      m[0][3] = translation(x, o);
      m[1][3] = translation(y, o);
      m[2][3] = translation(z, o);
      m[3][3] = 64'sd1 << FRAC;
    end
    for (int k = 0; k < 4; k++) begin
      r.row_idx = k[1:0];
      r.e0 = m[k][0][31:0];
      r.e1 = m[k][1][31:0];
      r.e2 = m[k][2][31:0];
      r.e3 = m[k][3][31:0];
      r.last = (k == 3);
      r.degen = !ok;
      rows_pending.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------- driving
  task automatic send_request(logic signed [31:0] ox, oy, oz, dx, dy, dz, ux, uy, uz);
    in_valid <= 1'b1;
    in_origin_x <= ox; in_origin_y <= oy; in_origin_z <= oz;
    in_dir_x <= dx;    in_dir_y <= dy;    in_dir_z <= dz;
    in_up_x <= ux;     in_up_y <= uy;     in_up_z <= uz;
    do @(posedge clk); while (in_stall);
    predict_view_rows('{ox, oy, oz}, '{dx, dy, dz}, '{ux, uy, uz});
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic idle_sender();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    idle_sender();
    while (rows_pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rnd_word();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
      2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // ---------------------------------------------------------------- stall
  initial begin
    @(posedge rst_n);
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------- check
  always @(posedge clk) begin
    row_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rows_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_ERRS) $display("unexpected row %0d", out_row_index);
      end else begin
        want = rows_pending.pop_front();
        if (out_row_index !== want.row_idx || out_entry_0 !== want.e0 ||
            out_entry_1 !== want.e1 || out_entry_2 !== want.e2 ||
            out_entry_3 !== want.e3 || out_last_row !== want.last ||
            out_degenerate !== want.degen) begin
          mismatches++;
          if (mismatches <= MAX_ERRS) begin
            $display("row mismatch exp: %0d %h %h %h %h l%b d%b", want.row_idx,
                     want.e0, want.e1, want.e2, want.e3, want.last, want.degen);
            $display("             got: %0d %h %h %h %h l%b d%b", out_row_index,
                     out_entry_0, out_entry_1, out_entry_2, out_entry_3,
                     out_last_row, out_degenerate);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests
  localparam logic signed [31:0] ONE = 32'sh1_0000;
  localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;

  task automatic test_basic_views();
    send_request(0, 0, 0, 0, 0, -ONE, 0, ONE, 0);
    send_request(ONE, 2 * ONE, 3 * ONE, ONE, 0, 0, 0, 0, ONE);
    send_request(-5 * ONE, 7, 9, 3, -4, 12, 1, 1, 0);
    send_request(MAXV, MINV, MAXV, MAXV, MAXV, MAXV, MINV, MAXV, 0);
    send_request(MINV, MINV, MINV, MINV, MINV, MINV, MAXV, 0, MINV);
    send_request(MAXV, MAXV, MAXV, 1, 0, 0, 0, 1, 0);
    send_request(MINV, MAXV, MINV, 0, MINV, 0, MAXV, 0, 0);
    send_request(MAXV, MAXV, MAXV, -ONE, -ONE, -ONE, ONE, -ONE, 0);
    send_request(32'shFFFF, -1, 1, MAXV, 1, -1, -1, MAXV, 1);
  endtask

  task automatic test_degenerate_views();
    send_request(ONE, ONE, ONE, 0, 0, 0, 0, ONE, 0);
    send_request(MAXV, MINV, 0, 0, 0, 0, 0, 0, 0);
    send_request(ONE, 0, 0, 0, ONE, 0, 0, 3 * ONE, 0);
    send_request(0, 0, 0, ONE, ONE, 0, -ONE, -ONE, 0);
    send_request(2, 3, 4, 5 * ONE, 0, 0, 0, 0, 0);
    send_request(0, 0, 0, MINV, 0, 0, MAXV, 0, 0);
    send_request(MINV, MAXV, 1, 3, 3, 3, 7, 7, 7);
  endtask

  task automatic test_random_views(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_request(rnd_word(), rnd_word(), rnd_word(), 0, 0, 0,
                     rnd_word(), rnd_word(), rnd_word());
      else
        send_request(rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(),
                     rnd_word(), rnd_word(), rnd_word(), rnd_word());
    end
  endtask

  initial begin
    int guard;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_views();
    test_degenerate_views();
    test_random_views(150);
    // hold the sender until the pipeline has emptied
    wait_drained();
    test_random_views(100);
    quiet = 1'b1;
    test_random_views(80);
    idle_sender();
    guard = 0;
    while (rows_pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && rows_pending.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("tb NOT OK");
    $finish;
  end
endmodule
